>>> design/cfe_pkg.sv
// Package for the CRC-framed command encoder: payload structs, opcodes,
// register indexes, CRC-16 constants and the CRC byte-update function.
`default_nettype none

package cfe_pkg;

    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int BURST_MAX  = 7;
    localparam int BURST_CNT_W = 3;

    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_TOP   = 16'h8000;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // Opcodes carried in the op field
    localparam logic OP_CMD   = 1'b0;
    localparam logic OP_PARAM = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] param_count;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_item;

    // Bytes produced by one item, handed from the frame builder to the serializer
    typedef struct packed {
        logic                                load;
        logic [BURST_CNT_W-1:0]              count;
        logic [BURST_MAX-1:0][BYTE_W-1:0]    bytes;
    } t_burst;

    // CRC-16 XMODEM, one byte, MSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/cfe_in_stage.sv
// Input register of the encoder: holds one accepted item until the frame
// builder takes it. Depends on cfe_pkg.
`default_nettype none

module cfe_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire cfe_pkg::t_in_item i_item,
    output logic                 o_stall,
    input  wire logic            i_take,
    output logic                 o_held_valid,
    output cfe_pkg::t_in_item    o_held_item
);
    import cfe_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_open;

    // Room when empty or when the held item leaves this cycle
    assign w_open = !r_valid || i_take;
    assign o_stall = !w_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_open) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_open && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_item  = r_item;

endmodule

`default_nettype wire

>>> design/cfe_frame_builder.sv
// Frame builder: configuration registers, CRC and frame state, and the
// byte burst each item produces. Depends on cfe_pkg.
`default_nettype none

module cfe_frame_builder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_held_valid,
    input  wire cfe_pkg::t_in_item i_held_item,
    input  wire logic              i_burst_free,
    output logic                   o_take,
    output cfe_pkg::t_burst        o_burst
);
    import cfe_pkg::*;

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_tail;
    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_left;
    logic              r_open;

    logic [CRC_W-1:0]  n_crc;
    logic [BYTE_W-1:0] n_left;
    logic              n_open;

    logic              w_is_cmd;
    logic [BYTE_W:0]   w_len;
    logic [BYTE_W-1:0] w_left_dec;
    t_burst            w_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            r_tail   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_TAIL:   r_tail   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign o_take     = i_held_valid && i_burst_free;
    assign w_is_cmd   = (i_held_item.op == OP_CMD);
    assign w_len      = {1'b0, i_held_item.param_count} + {{BYTE_W{1'b0}}, 1'b1};
    assign w_left_dec = r_left - {{(BYTE_W-1){1'b0}}, 1'b1};
    assign n_crc      = crc16_byte(w_is_cmd ? '0 : r_crc, i_held_item.data_byte);

    always_comb begin
        w_burst.load  = o_take;
        w_burst.count = '0;
        w_burst.bytes = '0;
        n_left        = r_left;
        n_open        = r_open;
        if (w_is_cmd) begin
            w_burst.bytes[0] = r_header;
            w_burst.bytes[1] = w_len[BYTE_W-1:0];
            w_burst.bytes[2] = {{(BYTE_W-1){1'b0}}, w_len[BYTE_W]};
            w_burst.bytes[3] = i_held_item.data_byte;
            if (i_held_item.param_count == '0) begin
                // Empty command closes the frame at once
                w_burst.bytes[4] = n_crc[BYTE_W-1:0];
                w_burst.bytes[5] = n_crc[CRC_W-1:BYTE_W];
                w_burst.bytes[6] = r_tail;
                w_burst.count    = 3'd7;
                n_left           = '0;
                n_open           = 1'b0;
            end else begin
                w_burst.count = 3'd4;
                n_left        = i_held_item.param_count;
                n_open        = 1'b1;
            end
        end else if (r_open) begin
            w_burst.bytes[0] = i_held_item.data_byte;
            n_left           = w_left_dec;
            if (w_left_dec == '0) begin
                w_burst.bytes[1] = n_crc[BYTE_W-1:0];
                w_burst.bytes[2] = n_crc[CRC_W-1:BYTE_W];
                w_burst.bytes[3] = r_tail;
                w_burst.count    = 3'd4;
                n_open           = 1'b0;
            end else begin
                w_burst.count = 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_left <= '0;
            r_open <= 1'b0;
        end else if (o_take && (w_is_cmd || r_open)) begin
            r_crc  <= n_crc;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

    assign o_burst = w_burst;

endmodule

`default_nettype wire

>>> design/cfe_serializer.sv
// Serializer: holds a burst of up to seven bytes and moves them one per
// cycle into the output register unless the output stalls. Depends on cfe_pkg.
`default_nettype none

module cfe_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cfe_pkg::t_burst i_burst,
    output logic                 o_burst_free,
    output logic                 o_valid,
    output cfe_pkg::t_out_item   o_item,
    input  wire logic            i_stall
);
    import cfe_pkg::*;

    logic [BURST_MAX-1:0][BYTE_W-1:0] r_bytes;
    logic [BURST_CNT_W-1:0]           r_cnt;
    logic                             r_out_valid;
    t_out_item                        r_out;

    logic w_out_open;
    logic w_pop;

    assign w_out_open   = !r_out_valid || !i_stall;
    assign w_pop        = (r_cnt != '0) && w_out_open;
    assign o_burst_free = (r_cnt == '0) || ((r_cnt == 3'd1) && w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_burst.load) begin
            r_cnt <= i_burst.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.load) begin
            r_bytes <= i_burst.bytes;
        end else if (w_pop) begin
            r_bytes <= r_bytes >> BYTE_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_open) begin
            r_out_valid <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out.out_byte <= r_bytes[0];
            r_out.last     <= (r_cnt == 3'd1);
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

>>> design/crc_framed_command_encoder_top.sv
// Top level of the CRC-16 framed command encoder: input register, frame
// builder and serializer. Depends on cfe_pkg and the three cfe_ modules.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | into      | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//   out     | out of    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//   cfg     | into      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each command or in-frame parameter yields a burst of bytes, sent one per
// cycle through the output register unless the output stalls; the burst
// buffer takes the next item as its last byte leaves. A mid-frame parameter
// yields 1 byte, an open command 4, the final parameter 4, an empty command 7.
// Synchronous active-low reset clears the frame state, both config registers
// and all valid flags. A stall on the output holds the output register and
// backs up into o_in_stall once the burst buffer and input register fill.
`default_nettype none

module crc_framed_command_encoder_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire cfe_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output cfe_pkg::t_out_item      o_out_item,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import cfe_pkg::*;

    logic     w_held_valid;
    t_in_item w_held_item;
    logic     w_take;
    logic     w_burst_free;
    t_burst   w_burst;

    // Config writes go straight into the registers, so the port never pushes back
    assign o_cfg_ready = 1'b1;

    cfe_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_item       (i_in_item),
        .o_stall      (o_in_stall),
        .i_take       (w_take),
        .o_held_valid (w_held_valid),
        .o_held_item  (w_held_item)
    );

    // Computes CRC and frame state, builds the whole burst combinationally
    cfe_frame_builder u_build (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_held_valid (w_held_valid),
        .i_held_item  (w_held_item),
        .i_burst_free (w_burst_free),
        .o_take       (w_take),
        .o_burst      (w_burst)
    );

    cfe_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_burst      (w_burst),
        .o_burst_free (w_burst_free),
        .o_valid      (o_out_valid),
        .o_item       (o_out_item),
        .i_stall      (i_out_stall)
    );

endmodule

`default_nettype wire

>>> design/cfe_checker.sv
// Port-level checker for the encoder top and its bind statement.
// Depends on cfe_pkg and crc_framed_command_encoder_top.
`default_nettype none

module cfe_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire cfe_pkg::t_out_item o_out_item,
    input wire logic               i_out_stall
);
    import cfe_pkg::*;

    // Nothing held right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_in_stall && !o_out_valid))
        else $error("stall or valid set right after reset");

    // A burst continues without gaps until its last byte
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=> o_out_valid)
        else $error("gap inside a frame burst");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output changed");

endmodule

bind crc_framed_command_encoder_top cfe_checker u_cfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

>>> dv/tb_crc_framed_command_encoder_top.sv
// Self-checking testbench for crc_framed_command_encoder_top: directed and random
// command/parameter streams under several idle and stall mixes.
// Depends on cfe_pkg and the encoder RTL.
`default_nettype none

module tb_crc_framed_command_encoder_top;

    import cfe_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 16;   // pipeline depth plus a 7-byte burst
    localparam int          PHASE_ITEMS   = 125;
    localparam logic [15:0] CRC16_POLY    = 16'h1021;

    // Expected frame bytes for the encoder, built from its own copy of the
    // frame state and the two configuration registers.
    class frame_scoreboard;
        t_out_item   frame_bytes_q[$];
        logic [7:0]  header_reg;
        logic [7:0]  tail_reg;
        logic [15:0] crc_run;
        logic [7:0]  params_remaining;
        bit          in_frame;
        int          errors;

        function new();
            header_reg       = 8'h00;
            tail_reg         = 8'h00;
            crc_run          = 16'h0000;
            params_remaining = 8'h00;
            in_frame         = 1'b0;
            errors           = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] val);
            if (idx == CFG_HEADER) begin
                header_reg = val;
            end else begin
                tail_reg = val;
            end
        endfunction

        // XMODEM byte update, MSB first
        function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) begin
                r = r[15] ? ((r << 1) ^ CRC16_POLY) : (r << 1);
            end
            return r;
        endfunction

        function void predict_frame_bytes(t_in_item it);
            logic [7:0] burst[$];
            logic [8:0] len;
            t_out_item  o;
            if (it.op == OP_CMD) begin
                // a command always restarts; any open frame is dropped silently
                len = {1'b0, it.param_count} + 9'd1;
                burst.push_back(header_reg);
                burst.push_back(len[7:0]);
                burst.push_back({7'b0, len[8]});
                burst.push_back(it.data_byte);
                crc_run = crc_next(16'h0000, it.data_byte);
                if (it.param_count == 8'h00) begin
                    in_frame = 1'b0;
                end else begin
                    params_remaining = it.param_count;
                    in_frame         = 1'b1;
                end
            end else begin
                if (!in_frame) return;  // stray parameter: nothing comes out
                burst.push_back(it.data_byte);
                crc_run          = crc_next(crc_run, it.data_byte);
                params_remaining = params_remaining - 8'd1;
                if (params_remaining == 8'h00) in_frame = 1'b0;
            end
            if (!in_frame) begin
                burst.push_back(crc_run[7:0]);
                burst.push_back(crc_run[15:8]);
                burst.push_back(tail_reg);
                params_remaining = 8'h00;
            end
            foreach (burst[i]) begin
                o.out_byte = burst[i];
                o.last     = (i == burst.size() - 1);
                frame_bytes_q.push_back(o);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (frame_bytes_q.size() == 0) begin
                $error("unexpected output: out_byte %02h last %0d", got.out_byte, got.last);
                errors++;
                return;
            end
            want = frame_bytes_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return frame_bytes_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = CFG_HEADER;
    logic [7:0] cfg_data  = 8'h00;

    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       cfg_ready;

    frame_scoreboard sb;
    int send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int items_sent     = 0;
    int cycle_count    = 0;

    int idle_tbl[4]  = '{0, 85, 0, 19};
    int stall_tbl[4] = '{0, 0, 85, 19};

    crc_framed_command_encoder_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver: one stall decision per edge, so out_stall sees a single NBA per step
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: every value read here is the pre-edge one, so each transfer is
    // seen exactly as the block sees it at that edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.predict_frame_bytes(in_item);
            if (out_valid && !out_stall) sb.check_result(out_item);
        end
    end

    // Watchdog: far beyond the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("crc_framed_command_encoder_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------
    // Optional idle gap, then hold the item until the transfer happens.
    // Valid is only lowered inside a gap, never in the step it is raised again.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [7:0] cmd, input logic [7:0] cnt);
        t_in_item it;
        it.op          = OP_CMD;
        it.data_byte   = cmd;
        it.param_count = cnt;
        send_item(it);
    endtask

    // param_count is don't-care for parameters but still gets toggled
    task automatic send_param(input logic [7:0] val, input logic [7:0] junk_cnt);
        t_in_item it;
        it.op          = OP_PARAM;
        it.data_byte   = val;
        it.param_count = junk_cnt;
        send_item(it);
    endtask

    // Sender pauses until every predicted byte has come out, then lets the
    // pipeline settle in case a stray parameter is still moving through.
    // One edge first, so the monitor has booked the last input transfer.
    task automatic wait_frames_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Config channel: both registers back to back, valid held across them
    task automatic set_config(input logic [7:0] hdr, input logic [7:0] tl);
        wait_frames_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HEADER;
        cfg_data  <= hdr;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_HEADER, hdr);
        cfg_index <= CFG_TAIL;
        cfg_data  <= tl;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_TAIL, tl);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed: field extremes, empty frames, stray parameters, abandoned
    // frames, and the 256-byte length of a full parameter count
    // ------------------------------------------------------------------
    task automatic run_directed();
        send_param(8'hFF, 8'hFF);             // no frame open after reset
        send_cmd(8'h00, 8'h00);               // empty frame, trailer at once
        send_cmd(8'hFF, 8'h00);
        send_cmd(8'h5A, 8'h02);
        send_param(8'h00, 8'h00);
        send_param(8'hFF, 8'hFF);             // closes frame
        send_param(8'h33, 8'h01);             // stray after a closed frame
        send_cmd(8'hC3, 8'h03);
        send_param(8'h81, 8'h7F);
        send_cmd(8'h7E, 8'h01);               // abandons the open frame
        send_param(8'h01, 8'h80);
        send_cmd(8'h10, 8'hFF);               // length 256 -> 00 01
        send_param(8'h42, 8'h55);
        send_cmd(8'h20, 8'h01);               // abandons the long frame
        send_param(8'hAA, 8'hAA);
        send_cmd(8'h99, 8'h80);
        send_param(8'h0F, 8'h0F);
        send_param(8'hF0, 8'hF0);
        send_cmd(8'hE7, 8'h01);
        send_param(8'h18, 8'h00);
    endtask

    // Random: mostly complete frames with random content, plus stray
    // parameters and frames cut short by the next command
    task automatic run_random_frames(input int n_items);
        int goal;
        int kind;
        int roll;
        int cnt;
        int n_par;
        bit paused;
        goal   = items_sent + n_items;
        paused = 1'b0;
        while (items_sent < goal) begin
            if (!paused && items_sent >= goal - n_items / 2) begin
                wait_frames_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 7) begin
                send_param(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    cnt = 255;
                end else if (roll < 6) begin
                    cnt = $urandom_range(7, 254);
                end else begin
                    cnt = $urandom_range(0, 6);
                end
                n_par = cnt;
                if (kind < 17 && cnt > 0) n_par = $urandom_range(0, cnt - 1);
                // keep the phase near its item budget; a cut frame is abandoned later
                if (n_par > goal - items_sent - 1) n_par = goal - items_sent - 1;
                send_cmd(8'($urandom_range(0, 255)), 8'(cnt));
                repeat (n_par) begin
                    send_param(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'hA5, 8'h5A);
        run_directed();

        // one idling mix per phase, configs include both register extremes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_config(8'h00, 8'hFF);
                1: set_config(8'hFF, 8'h00);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            send_idle_pct  = idle_tbl[ph];
            recv_stall_pct = stall_tbl[ph];
            run_random_frames(PHASE_ITEMS);
        end

        wait_frames_drained();

        if (sb.pending() != 0) begin
            $error("%0d expected output bytes never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("crc_framed_command_encoder_top test passed");
        end else begin
            $display("crc_framed_command_encoder_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> crc_framed_command_encoder_top.f
design/cfe_pkg.sv
design/cfe_in_stage.sv
design/cfe_frame_builder.sv
design/cfe_serializer.sv
design/crc_framed_command_encoder_top.sv
design/cfe_checker.sv
dv/tb_crc_framed_command_encoder_top.sv
